### rtl/mbpm_pkg.sv
// ----------------------------------------------------------------------------
// mbpm_pkg
// Shared types and constants for the masked byte pattern match counter.
// ----------------------------------------------------------------------------
package mbpm_pkg;

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_SCAN  = 1'b1;
    localparam logic [1:0] HIT_LIMIT = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] value;
        logic       care;
        logic       last;
    } mbpm_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] match_count;
    } mbpm_out_t;

    // per-transaction controls broadcast to every cell
    typedef struct packed {
        logic load;   // pattern byte accepted
        logic scan;   // data byte accepted
        logic flush;  // end of scan: drop partial matches
        logic last;   // final byte of pattern or scan
    } mbpm_ctl_t;

endpackage

### rtl/masked_byte_pattern_match_counter.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_match_counter
// Throughput: one transaction per cycle, pattern or data bytes alike, while no unaccepted status holds the input.
// Output: the status appears registered in the cycle after the final data byte.
// Each cell compares against the broadcast data byte; partial matches ripple.
// Reset: no pattern, window empty, no hits; pattern storage is unset.
// ----------------------------------------------------------------------------
module masked_byte_pattern_match_counter #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mbpm_pkg::mbpm_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mbpm_pkg::mbpm_out_t out_data
);
    import mbpm_pkg::*;

    localparam int LIDX_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LIDX_W-1:0] MAX_IDX  = LIDX_W'(MAX_PATTERN);
    localparam logic [LIDX_W-1:0] LAST_IDX = LIDX_W'(MAX_PATTERN - 1);

    logic                   accept;
    mbpm_ctl_t              ctl;
    logic [LIDX_W-1:0]      load_idx_reg;
    logic [LIDX_W-1:0]      load_idx_next;
    logic [LIDX_W-1:0]      last_pos;
    logic [1:0]             hits_reg;
    logic [1:0]             hits_next;
    logic [1:0]             hits_now;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    mbpm_out_t              out_data_reg;
    logic [MAX_PATTERN:0]   chain;
    logic [MAX_PATTERN-1:0] cell_match;
    logic                   any_match;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign ctl.load  = accept && (in_data.cmd == CMD_LOAD);
    assign ctl.scan  = accept && (in_data.cmd == CMD_SCAN);
    assign ctl.flush = ctl.scan && in_data.last;
    assign ctl.last  = in_data.last;

    assign last_pos = (load_idx_reg < MAX_IDX) ? load_idx_reg : LAST_IDX;

    assign chain[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        mbpm_cell #(
            .IDX   (k),
            .IDX_W (LIDX_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .value    (in_data.value),
            .care     (in_data.care),
            .load_idx (load_idx_reg),
            .last_pos (last_pos),
            .prev_hit (chain[k]),
            .hit      (chain[k+1]),
            .match    (cell_match[k])
        );
    end

    assign any_match = |cell_match;

    always_comb
    begin
        load_idx_next = load_idx_reg;
        if (ctl.load)
        begin
            if (in_data.last)
            begin
                load_idx_next = '0;
            end
            else if (load_idx_reg < MAX_IDX)
            begin
                load_idx_next = load_idx_reg + LIDX_W'(1);
            end
        end
    end

    always_comb
    begin
        hits_now = hits_reg;
        if (any_match && (hits_reg < HIT_LIMIT))
        begin
            hits_now = hits_reg + 2'd1;
        end
    end

    always_comb
    begin
        hits_next = hits_reg;
        if (ctl.load || ctl.flush)
        begin
            hits_next = '0;
        end
        else if (ctl.scan)
        begin
            hits_next = hits_now;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.flush)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg  <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_idx_reg  <= load_idx_next;
            hits_reg      <= hits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.flush)
        begin
            out_data_reg.status      <= hits_now;
            out_data_reg.match_count <= hits_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/mbpm_cell.sv
// ----------------------------------------------------------------------------
// mbpm_cell
// One pattern position: holds its pattern byte and care bit, and the partial
// match flag handed on to the next position each data cycle.
// ----------------------------------------------------------------------------
module mbpm_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mbpm_pkg::mbpm_ctl_t ctl,
    input  logic [7:0]         value,
    input  logic               care,
    input  logic [IDX_W-1:0]   load_idx,
    input  logic [IDX_W-1:0]   last_pos,
    input  logic               prev_hit,
    output logic               hit,
    output logic               match
);
    import mbpm_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [7:0] pat_reg;
    logic       care_reg;
    logic       hit_reg;
    logic       hit_next;
    logic       tail_reg;
    logic       tail_next;
    logic       byte_ok;

    assign byte_ok = !care_reg || (value == pat_reg);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.load || ctl.flush)
        begin
            hit_next = 1'b0;
        end
        else if (ctl.scan)
        begin
            hit_next = prev_hit && byte_ok;
        end
    end

    always_comb
    begin
        tail_next = tail_reg;
        if (ctl.load)
        begin
            tail_next = ctl.last && (last_pos == MY_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && (load_idx == MY_IDX))
        begin
            pat_reg  <= value;
            care_reg <= care;
        end
    end

    assign hit   = hit_reg;
    assign match = tail_reg && ctl.scan && prev_hit && byte_ok;

endmodule

### bench/mbpm_checker.sv
// ----------------------------------------------------------------------------
// mbpm_checker
// Watches both channels of the pattern match counter, keeps its own copy of
// the pattern, window and hit count, and compares every status transaction
// with the oldest predicted one. Reports the number of failures.
// ----------------------------------------------------------------------------
module mbpm_checker #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  mbpm_pkg::mbpm_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  mbpm_pkg::mbpm_out_t out_data,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mbpm_pkg::*;

    logic [7:0] pat_byte [MAX_PATTERN];
    logic       pat_care [MAX_PATTERN];
    logic [7:0] win      [MAX_PATTERN];
    logic [6:0] load_idx;
    logic [6:0] pat_len;
    logic [6:0] seen;
    logic [1:0] hits;
    mbpm_out_t  status_q [$];
    mbpm_out_t  want;

    function automatic bit window_hit();
        if (pat_len == 0 || seen < pat_len)
            return 1'b0;
        for (int k = 0; k < pat_len; k++)
            if (pat_care[k] && win[pat_len - 1 - k] != pat_byte[k])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic track_transaction(input mbpm_in_t t);
        if (t.cmd == CMD_LOAD)
        begin
            pat_len = '0;
            seen    = '0;
            hits    = '0;
            if (load_idx < MAX_PATTERN)
            begin
                pat_byte[load_idx] = t.value;
                pat_care[load_idx] = t.care;
                load_idx++;
            end
            if (t.last)
            begin
                pat_len  = load_idx;
                load_idx = '0;
            end
        end
        else
        begin
            for (int i = MAX_PATTERN - 1; i > 0; i--)
                win[i] = win[i - 1];
            win[0] = t.value;
            if (seen < MAX_PATTERN)
                seen++;
            if (window_hit() && hits < HIT_LIMIT)
                hits++;
            if (t.last)
            begin
                status_q.push_back('{status: hits, match_count: hits});
                hits = '0;
                seen = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                pat_byte[i] = '0;
                pat_care[i] = 1'b0;
                win[i]      = '0;
            end
            load_idx   = '0;
            pat_len    = '0;
            seen       = '0;
            hits       = '0;
            status_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // input first: a same-edge result still pairs with the oldest entry
            if (in_valid && in_ready)
                track_transaction(in_data);
            if (out_valid && out_ready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("unexpected transaction: status=%0d match_count=%0d",
                           out_data.status, out_data.match_count);
                    fail_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.match_count !== want.match_count)
                    begin
                        $error("match_count: expected %0d, got %0d",
                               want.match_count, out_data.match_count);
                        fail_count++;
                    end
                end
            end
            pending = status_q.size();
        end
    end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives pattern loads and data scans into the masked byte pattern match
// counter: a directed opening, then random patterns with copies planted in
// the streams, stray loads and unfinished patterns. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbpm_pkg::*;

    localparam int MAX_PAT    = 64;
    localparam int NUM_ITEMS  = 1750;
    localparam int IDLE_LIMIT = 1000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    mbpm_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    mbpm_out_t out_data;
    int        fail_count;
    int        pending;

    int         items_sent = 0;
    int         idle_cycles = 0;
    bit         src_burst = 1'b0;
    bit         sink_burst = 1'b0;
    bit         pat_open = 1'b0;
    logic [7:0] cur_val  [$];
    logic       cur_care [$];

    masked_byte_pattern_match_counter #(
        .MAX_PATTERN(MAX_PAT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    mbpm_checker #(
        .MAX_PATTERN(MAX_PAT)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** masked_byte_pattern_match_counter: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic op, input logic [7:0] byte_val,
                             input logic care_bit, input logic last_bit);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cmd: op, value: byte_val, care: care_bit, last: last_bit};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic load_byte(input logic [7:0] byte_val, input logic care_bit,
                             input logic last_bit);
        if (!pat_open)
        begin
            cur_val.delete();
            cur_care.delete();
        end
        cur_val.push_back(byte_val);
        cur_care.push_back(care_bit);
        pat_open = !last_bit;
        send_byte(CMD_LOAD, byte_val, care_bit, last_bit);
    endtask

    task automatic scan_byte(input logic [7:0] byte_val, input logic last_bit);
        send_byte(CMD_SCAN, byte_val, 1'($urandom_range(0, 1)), last_bit);
    endtask

    task automatic load_pattern(input int len, input bit finish);
        for (int i = 0; i < len; i++)
            load_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                      finish && (i == len - 1));
    endtask

    // random stream with copies of the current pattern planted in it
    task automatic scan_stream(input int len, input int copies);
        logic [7:0] stream [];
        int usable;
        int at;
        int noise_at;
        stream = new[len];
        usable = (cur_val.size() > MAX_PAT) ? MAX_PAT : cur_val.size();
        foreach (stream[i])
            stream[i] = 8'($urandom_range(0, 255));
        if (!pat_open && usable > 0 && len >= usable)
        begin
            repeat (copies)
            begin
                at = $urandom_range(0, len - usable);
                for (int k = 0; k < usable; k++)
                    if (cur_care[k])
                        stream[at + k] = cur_val[k];
            end
        end
        noise_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++)
        begin
            if (i == noise_at)
                load_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            scan_byte(stream[i], i == len - 1);
        end
    endtask

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = sink_burst ? 0 : $urandom_range(0, 6);
            if (gap == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                @(posedge clk);
                while (!out_valid)
                    @(posedge clk);
                repeat (gap) @(negedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
            if ($urandom_range(0, 7) == 0)
                sink_burst = !sink_burst;
        end
    end

    initial
    begin
        int sel;
        int plen;
        int usable;
        int slen;
        in_valid = 1'b0;
        in_data  = '0;
        rst_n    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no pattern yet
        scan_byte(8'h00, 1'b1);
        // pattern 00 ?? FF, two overlapping-free hits, then too short, then one
        load_byte(8'h00, 1'b1, 1'b0);
        load_byte(8'hFF, 1'b0, 1'b0);
        load_byte(8'hFF, 1'b1, 1'b1);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h12, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hAB, 1'b0);
        scan_byte(8'hFF, 1'b1);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b1);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h55, 1'b0);
        scan_byte(8'hFF, 1'b1);
        // single byte pattern
        load_byte(8'h80, 1'b1, 1'b1);
        scan_byte(8'h80, 1'b1);
        // load in the middle of a scan
        scan_byte(8'h80, 1'b0);
        load_byte(8'h7F, 1'b0, 1'b1);
        scan_byte(8'h01, 1'b1);
        // unfinished pattern, then completed
        load_byte(8'hAA, 1'b1, 1'b0);
        scan_byte(8'h7F, 1'b1);
        load_byte(8'h55, 1'b1, 1'b1);
        scan_byte(8'hAA, 1'b0);
        scan_byte(8'h55, 1'b1);

        while (items_sent < NUM_ITEMS)
        begin
            src_burst = ($urandom_range(0, 3) == 0);
            if (pat_open || cur_val.size() == 0 || $urandom_range(0, 3) == 0)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 12)
                    plen = $urandom_range(1, 8);
                else if (sel < 17)
                    plen = $urandom_range(9, 24);
                else if (sel < 19)
                    plen = $urandom_range(25, MAX_PAT);
                else
                    plen = $urandom_range(MAX_PAT + 1, MAX_PAT + 6);
                load_pattern(plen, $urandom_range(0, 9) != 0);
            end
            usable = (cur_val.size() > MAX_PAT) ? MAX_PAT : cur_val.size();
            if (usable > 1 && $urandom_range(0, 5) == 0)
                slen = $urandom_range(1, usable);
            else
                slen = usable + $urandom_range(0, 16);
            if (slen < 1)
                slen = 1;
            scan_stream(slen, $urandom_range(0, 3));
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("** masked_byte_pattern_match_counter: PASSED **");
        else
            $display("** masked_byte_pattern_match_counter: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/mbpm_pkg.sv
rtl/mbpm_cell.sv
rtl/masked_byte_pattern_match_counter.sv
bench/mbpm_checker.sv
bench/tb_top.sv
